[rtl/core/b2r_pkg.sv]
// ----------------------------------------------------------------------------
// b2r_pkg
// shared types, constants and symbol lookup for the roman numeral encoder
// ----------------------------------------------------------------------------
package b2r_pkg;

    localparam int unsigned VALUE_W = 12;
    localparam int unsigned SYM_W   = 8;
    localparam int unsigned DIGIT_W = 4;
    localparam int unsigned PLACE_W = 2;
    localparam int unsigned IDX_W   = 2;

    localparam logic [VALUE_W-1:0] MAX_VALUE = 12'd3999;
    localparam logic [DIGIT_W-1:0] FIVE      = 4'd5;
    localparam logic [DIGIT_W-1:0] FOUR      = 4'd4;
    localparam logic [DIGIT_W-1:0] NINE      = 4'd9;

    localparam logic [SYM_W-1:0] SYM_NONE = 8'h00;
    localparam logic [SYM_W-1:0] SYM_I    = 8'h49;
    localparam logic [SYM_W-1:0] SYM_V    = 8'h56;
    localparam logic [SYM_W-1:0] SYM_X    = 8'h58;
    localparam logic [SYM_W-1:0] SYM_L    = 8'h4C;
    localparam logic [SYM_W-1:0] SYM_C    = 8'h43;
    localparam logic [SYM_W-1:0] SYM_D    = 8'h44;
    localparam logic [SYM_W-1:0] SYM_M    = 8'h4D;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_EMIT,
        S_ZERO
    } t_state;

    function automatic logic [VALUE_W-1:0] place_weight(input logic [PLACE_W-1:0] place);
        logic [VALUE_W-1:0] w;
        case (place)
            2'd3:    w = 12'd1000;
            2'd2:    w = 12'd100;
            2'd1:    w = 12'd10;
            default: w = 12'd1;
        endcase
        return w;
    endfunction

    function automatic logic [SYM_W-1:0] sym_one(input logic [PLACE_W-1:0] place);
        logic [SYM_W-1:0] s;
        case (place)
            2'd3:    s = SYM_M;
            2'd2:    s = SYM_C;
            2'd1:    s = SYM_X;
            default: s = SYM_I;
        endcase
        return s;
    endfunction

    function automatic logic [SYM_W-1:0] sym_five(input logic [PLACE_W-1:0] place);
        logic [SYM_W-1:0] s;
        case (place)
            2'd3:    s = SYM_NONE;
            2'd2:    s = SYM_D;
            2'd1:    s = SYM_L;
            default: s = SYM_V;
        endcase
        return s;
    endfunction

    function automatic logic [SYM_W-1:0] sym_ten(input logic [PLACE_W-1:0] place);
        logic [SYM_W-1:0] s;
        case (place)
            2'd3:    s = SYM_NONE;
            2'd2:    s = SYM_M;
            2'd1:    s = SYM_C;
            default: s = SYM_X;
        endcase
        return s;
    endfunction

    // index of the final character of a nonzero digit
    function automatic logic [IDX_W-1:0] last_idx(input logic [DIGIT_W-1:0] digit);
        logic [DIGIT_W-1:0] n;
        if (digit == NINE || digit == FOUR) begin
            n = 4'd1;
        end else if (digit >= FIVE) begin
            n = digit - FIVE;
        end else begin
            n = digit - 4'd1;
        end
        return n[IDX_W-1:0];
    endfunction

    function automatic logic [SYM_W-1:0] digit_sym(input logic [PLACE_W-1:0] place,
                                                   input logic [DIGIT_W-1:0] digit,
                                                   input logic [IDX_W-1:0]   idx);
        logic [SYM_W-1:0] s;
        if (digit == NINE) begin
            s = (idx == '0) ? sym_one(place) : sym_ten(place);
        end else if (digit == FOUR) begin
            s = (idx == '0) ? sym_one(place) : sym_five(place);
        end else if (digit >= FIVE) begin
            s = (idx == '0) ? sym_five(place) : sym_one(place);
        end else begin
            s = sym_one(place);
        end
        return s;
    endfunction

endpackage

[rtl/core/binary_to_roman_numeral_encoder.sv]
// ----------------------------------------------------------------------------
// binary_to_roman_numeral_encoder
// converts a 12-bit unsigned value to its roman numeral, one ascii symbol
// per output beat, most significant digit first
// ----------------------------------------------------------------------------
// usage:
//   a value is taken at a rising edge with start high and busy low; values
//   above 3999 are clamped to 3999. busy falls in the cycle that the final
//   symbol is on the ports.
//   each symbol appears on o_symbol for one cycle with o_strobe high; o_last
//   marks the final symbol. a zero value gives one beat with symbol 0.
//   the receiver cannot stall: every strobe is a delivered beat.
// timing:
//   one compare-subtract unit peels each decimal place by repeated
//   subtraction of 1000, 100, 10 and 1, one step per cycle. a place with
//   digit d is extracted by d subtractions and one failed compare, then its
//   symbols are emitted. before the first symbol, each leading zero place is
//   passed over, then the leading digit is extracted.
//   the longest conversion from accept to next accept is that of 3888.
//   lower places are skipped once the remainder reaches zero.
// reset:
//   synchronous active-low reset returns to idle with no strobe pending.
// ----------------------------------------------------------------------------
module binary_to_roman_numeral_encoder (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    input  logic [b2r_pkg::VALUE_W-1:0]    i_value,
    output logic                           busy,
    output logic                           o_strobe,
    output logic [b2r_pkg::SYM_W-1:0]      o_symbol,
    output logic                           o_last
);

    b2r_pkg::t_state               r_state,  n_state;
    logic [b2r_pkg::VALUE_W-1:0]   r_rem,    n_rem;
    logic [b2r_pkg::PLACE_W-1:0]   r_place,  n_place;
    logic [b2r_pkg::DIGIT_W-1:0]   r_digit,  n_digit;
    logic [b2r_pkg::IDX_W-1:0]     r_idx,    n_idx;
    logic                          r_strobe, n_strobe;
    logic [b2r_pkg::SYM_W-1:0]     r_sym,    n_sym;
    logic                          r_last,   n_last;

    logic                          accept;
    logic [b2r_pkg::VALUE_W:0]     diff;
    logic                          ge;
    logic                          digit_end;

    assign accept = start && (r_state == b2r_pkg::S_IDLE);

    // shared compare-subtract unit
    assign diff      = {1'b0, r_rem} - {1'b0, b2r_pkg::place_weight(r_place)};
    assign ge        = !diff[b2r_pkg::VALUE_W];
    assign digit_end = (r_idx == b2r_pkg::last_idx(r_digit));

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            b2r_pkg::S_IDLE: begin
                if (accept) begin
                    n_state = (i_value == '0) ? b2r_pkg::S_ZERO : b2r_pkg::S_DIV;
                end
            end
            b2r_pkg::S_DIV: begin
                if (!ge) begin
                    if (r_digit != '0) begin
                        n_state = b2r_pkg::S_EMIT;
                    end else if (r_place == '0) begin
                        n_state = b2r_pkg::S_IDLE;
                    end
                end
            end
            b2r_pkg::S_EMIT: begin
                if (digit_end) begin
                    n_state = (r_rem == '0) ? b2r_pkg::S_IDLE : b2r_pkg::S_DIV;
                end
            end
            b2r_pkg::S_ZERO: begin
                n_state = b2r_pkg::S_IDLE;
            end
            default: begin
                n_state = b2r_pkg::S_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_rem    = r_rem;
        n_place  = r_place;
        n_digit  = r_digit;
        n_idx    = r_idx;
        n_strobe = 1'b0;
        n_sym    = r_sym;
        n_last   = r_last;
        case (r_state)
            b2r_pkg::S_IDLE: begin
                if (accept) begin
                    n_rem   = (i_value > b2r_pkg::MAX_VALUE) ? b2r_pkg::MAX_VALUE : i_value;
                    n_place = 2'd3;
                    n_digit = '0;
                    n_idx   = '0;
                end
            end
            b2r_pkg::S_DIV: begin
                if (ge) begin
                    n_rem   = diff[b2r_pkg::VALUE_W-1:0];
                    n_digit = r_digit + 4'd1;
                end else begin
                    n_idx = '0;
                    if (r_digit == '0) begin
                        n_place = r_place - 2'd1;
                    end
                end
            end
            b2r_pkg::S_EMIT: begin
                n_strobe = 1'b1;
                n_sym    = b2r_pkg::digit_sym(r_place, r_digit, r_idx);
                n_last   = digit_end && (r_rem == '0);
                n_idx    = r_idx + 2'd1;
                if (digit_end) begin
                    n_place = r_place - 2'd1;
                    n_digit = '0;
                end
            end
            b2r_pkg::S_ZERO: begin
                n_strobe = 1'b1;
                n_sym    = b2r_pkg::SYM_NONE;
                n_last   = 1'b1;
            end
            default: begin
                n_strobe = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= b2r_pkg::S_IDLE;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem   <= n_rem;
        r_place <= n_place;
        r_digit <= n_digit;
        r_idx   <= n_idx;
        r_sym   <= n_sym;
        r_last  <= n_last;
    end

    assign busy     = (r_state != b2r_pkg::S_IDLE);
    assign o_strobe = r_strobe;
    assign o_symbol = r_sym;
    assign o_last   = r_last;

    a_strobe_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> ($past(r_state) == b2r_pkg::S_EMIT || $past(r_state) == b2r_pkg::S_ZERO))
        else $error("strobe without an emitting state");

    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_last) |-> !busy)
        else $error("busy after final beat");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted value did not raise busy");

    a_digit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == b2r_pkg::S_EMIT) |-> (r_digit != '0 && r_digit <= b2r_pkg::NINE))
        else $error("digit out of range while emitting");

    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> (r_rem <= b2r_pkg::MAX_VALUE))
        else $error("remainder out of range");

endmodule

[verif/binary_to_roman_numeral_encoder_test.sv]
// ----------------------------------------------------------------------------
// binary_to_roman_numeral_encoder_test
// self-checking bench for the roman numeral encoder: values go in through
// start/busy, every symbol beat on o_strobe is checked against a numeral
// built by an independent encoder, with fixed numerals for the edge rows
// ----------------------------------------------------------------------------
module binary_to_roman_numeral_encoder_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned NUM_RANDOM = 456;

    typedef logic [b2r_pkg::VALUE_W-1:0] t_value;
    typedef logic [b2r_pkg::SYM_W-1:0]   t_sym;

    typedef struct {
        t_value value;
        bit     fixed;
        string  numeral;
    } t_row;

    typedef struct {
        bit    fixed;
        string numeral;
    } t_pending;

    typedef struct {
        t_sym symbol;
        logic last;
    } t_beat;

    logic   i_clk   = 1'b0;
    logic   i_rst_n = 1'b0;
    logic   start   = 1'b0;
    t_value i_value = '0;
    logic   busy;
    logic   o_strobe;
    t_sym   o_symbol;
    logic   o_last;

    t_pending numeral_requests[$];
    t_beat    expected_beats[$];
    int       n_issued    = 0;
    int       n_accepted  = 0;
    int       n_beats     = 0;
    int       n_zero      = 0;
    int       n_clamped   = 0;
    int       n_errors    = 0;

    t_row directed_rows [0:24] = '{
        '{12'd0,    1'b1, ""},
        '{12'd1,    1'b1, "I"},
        '{12'd4,    1'b1, "IV"},
        '{12'd9,    1'b1, "IX"},
        '{12'd3,    1'b0, ""},
        '{12'd5,    1'b0, ""},
        '{12'd8,    1'b0, ""},
        '{12'd10,   1'b1, "X"},
        '{12'd40,   1'b0, ""},
        '{12'd50,   1'b0, ""},
        '{12'd90,   1'b0, ""},
        '{12'd100,  1'b1, "C"},
        '{12'd400,  1'b0, ""},
        '{12'd500,  1'b0, ""},
        '{12'd900,  1'b0, ""},
        '{12'd1000, 1'b1, "M"},
        '{12'd3000, 1'b1, "MMM"},
        '{12'd1994, 1'b0, ""},
        '{12'd12,   1'b0, ""},
        '{12'd1024, 1'b0, ""},
        '{12'd2048, 1'b0, ""},
        '{12'd3888, 1'b1, "MMMDCCCLXXXVIII"},
        '{12'd3999, 1'b1, "MMMCMXCIX"},
        '{12'd4000, 1'b1, "MMMCMXCIX"},
        '{12'd4095, 1'b1, "MMMCMXCIX"}
    };

    binary_to_roman_numeral_encoder i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_value  (i_value),
        .busy     (busy),
        .o_strobe (o_strobe),
        .o_symbol (o_symbol),
        .o_last   (o_last)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    function automatic string roman_of(input t_value raw);
        int    v;
        int    weight;
        int    digit;
        int    p;
        int    k;
        t_sym  one_s;
        t_sym  five_s;
        t_sym  ten_s;
        string s;
        v = (raw > b2r_pkg::MAX_VALUE) ? int'(b2r_pkg::MAX_VALUE) : int'(raw);
        s = "";
        weight = 1000;
        for (p = 3; p >= 0; p--) begin
            digit = (v / weight) % 10;
            weight = weight / 10;
            case (p)
                3: begin
                    one_s = b2r_pkg::SYM_M; five_s = b2r_pkg::SYM_NONE; ten_s = b2r_pkg::SYM_NONE;
                end
                2: begin
                    one_s = b2r_pkg::SYM_C; five_s = b2r_pkg::SYM_D; ten_s = b2r_pkg::SYM_M;
                end
                1: begin
                    one_s = b2r_pkg::SYM_X; five_s = b2r_pkg::SYM_L; ten_s = b2r_pkg::SYM_C;
                end
                default: begin
                    one_s = b2r_pkg::SYM_I; five_s = b2r_pkg::SYM_V; ten_s = b2r_pkg::SYM_X;
                end
            endcase
            if (digit == 9) begin
                s = $sformatf("%s%c%c", s, one_s, ten_s);
            end else if (digit == 4) begin
                s = $sformatf("%s%c%c", s, one_s, five_s);
            end else begin
                if (digit >= 5) begin
                    s = $sformatf("%s%c", s, five_s);
                    digit -= 5;
                end
                for (k = 0; k < digit; k++) begin
                    s = $sformatf("%s%c", s, one_s);
                end
            end
        end
        return s;
    endfunction

    // accepted values turn into expected beats; an empty numeral is one null beat
    always @(posedge i_clk) begin
        t_pending req;
        t_beat    b;
        string    numeral;
        int       k;
        if (i_rst_n && start && !busy) begin
            req = numeral_requests.pop_front();
            numeral = req.fixed ? req.numeral : roman_of(i_value);
            n_accepted++;
            if (i_value == '0) n_zero++;
            if (i_value > b2r_pkg::MAX_VALUE) n_clamped++;
            if (numeral.len() == 0) begin
                b.symbol = b2r_pkg::SYM_NONE;
                b.last   = 1'b1;
                expected_beats = {expected_beats, b};
            end else begin
                for (k = 0; k < numeral.len(); k++) begin
                    b.symbol = numeral[k];
                    b.last   = (k == numeral.len() - 1);
                    expected_beats = {expected_beats, b};
                end
            end
        end
    end

    always @(posedge i_clk) begin
        t_beat want;
        if (i_rst_n && o_strobe) begin
            n_beats++;
            if (expected_beats.size() == 0) begin
                $display("%0t: unexpected beat, expected none, got symbol %02h last %0b",
                         $time, o_symbol, o_last);
                n_errors++;
            end else begin
                want = expected_beats.pop_front();
                if (o_symbol !== want.symbol || o_last !== want.last) begin
                    $display("%0t: beat mismatch, expected symbol %02h last %0b, got %02h %0b",
                             $time, want.symbol, want.last, o_symbol, o_last);
                    n_errors++;
                end
            end
        end
    end

    task automatic send_value(input t_value value, input bit fixed,
                              input string numeral, input bit allow_gaps);
        int       gap;
        t_pending req;
        gap = 0;
        if (allow_gaps && $urandom_range(0, 99) < 25) gap = $urandom_range(1, 2);
        if (gap > 0) begin
            start <= 1'b0;
            do @(posedge i_clk); while (busy);
            repeat (gap - 1) @(posedge i_clk);
        end
        req.fixed   = fixed;
        req.numeral = numeral;
        numeral_requests = {numeral_requests, req};
        start   <= 1'b1;
        i_value <= value;
        n_issued++;
        do @(posedge i_clk); while (busy);
    endtask

    function automatic t_value random_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 4) return '0;
        if (r < 10) return t_value'($urandom_range(4000, 4095));
        return t_value'($urandom_range(1, 3999));
    endfunction

    initial begin
        int n;
        int drain;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (n = 0; n < $size(directed_rows); n++) begin
            send_value(directed_rows[n].value, directed_rows[n].fixed,
                       directed_rows[n].numeral, 1'b1);
        end
        // middle third runs back to back with start held high
        for (n = 0; n < NUM_RANDOM; n++) begin
            send_value(random_value(), 1'b0, "", n < 152 || n >= 304);
        end
        start <= 1'b0;

        drain = 0;
        while ((n_accepted != n_issued || expected_beats.size() != 0) && drain < 4000) begin
            @(posedge i_clk);
            drain++;
        end
        repeat (64) @(posedge i_clk);
        if (expected_beats.size() != 0) begin
            $display("%0t: %0d expected beats never arrived, expected symbol %02h, got none",
                     $time, expected_beats.size(), expected_beats[0].symbol);
            n_errors++;
        end

        $display("values converted: %0d (%0d zero, %0d clamped above 3999), symbol beats: %0d",
                 n_accepted, n_zero, n_clamped, n_beats);
        $display("mismatches: %0d", n_errors);
        if (n_errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("%0t: timeout", $time);
        $display("status: fail");
        $finish;
    end

endmodule

[binary_to_roman_numeral_encoder.f]
rtl/core/b2r_pkg.sv
rtl/core/binary_to_roman_numeral_encoder.sv
verif/binary_to_roman_numeral_encoder_test.sv
